// ===== rtl/izps_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer zoom pixel scaler package
// Payload types, register indexes and fixed field widths shared by the scaler.
// ----------------------------------------------------------------------------
package izps_pkg;

	localparam int COORD_BITS = 12;
	localparam int PIX_W      = 8;
	localparam int ZOOM_W     = 4;
	localparam int DIM_W      = 13;
	localparam int BASE_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_ZOOM_ROWS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHRINK_ROWS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM_COLS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHRINK_COLS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_ROWS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_COLS   = 3'd5;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             row_end;
		logic             frame_end;
	} izps_in_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] write_row;
		logic [COORD_BITS-1:0] write_col;
		logic [PIX_W-1:0]      pixel_out;
		logic                  last_write;
	} izps_out_t;

endpackage

// ===== rtl/integer_zoom_pixel_scaler.sv =====
// ----------------------------------------------------------------------------
// Integer zoom pixel scaler
// Nearest-neighbor image zoom with per-axis integer factors, emitting
// addressed, clipped destination writes.
// ----------------------------------------------------------------------------
// Usage:
// Source pixels arrive in raster order on the src channel (valid/ready) with
// row-end and frame-end marks. Each accepted pixel causes zero or more
// destination writes on the dst channel (valid/ready), each carrying row,
// column, value and a mark on the last write of that pixel. A pixel whose
// writes all fall outside the destination causes no transfer at all.
// The configuration port writes one register per cycle with cfg_we; it must
// only be used while the block is idle.
// The first write passes the replica stage, then the output register. A
// pixel holds the replica counters for its rows x cols writes (up to
// MAX_ZOOM^2), one write per cycle unless dst_ready stalls, so with neither
// axis expanding it is one pixel per cycle. The next pixel is taken in the
// same cycle the previous pixel's last write enters the output register.
// The output register holds a write while dst_ready is low; the counters
// then stall and src_ready drops once the current pixel is pending.
// Reset clears all counters and loads zoom 1, expand, and 4096 x 4096.
// ----------------------------------------------------------------------------
module integer_zoom_pixel_scaler #(
	parameter int MAX_ZOOM = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               src_valid,
	output logic                               src_ready,
	input  izps_pkg::izps_in_t                 src,
	output logic                               dst_valid,
	input  logic                               dst_ready,
	output izps_pkg::izps_out_t                dst,
	input  logic                               cfg_we,
	input  logic [izps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [izps_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import izps_pkg::*;

	localparam int CNT_W = $clog2(MAX_ZOOM + 1);
	localparam int LIM   = 1 << COORD_BITS;
	localparam int CMP_W = BASE_W + 1;

	// Configuration registers
	logic [ZOOM_W-1:0] zoom_rows_q, zoom_cols_q;
	logic              shrink_rows_q, shrink_cols_q;
	logic [DIM_W-1:0]  dest_rows_q, dest_cols_q;

	// Position state
	logic [BASE_W-1:0] row_base_q, col_base_q;
	logic [CNT_W-1:0]  row_phase_q, col_phase_q;

	// Replica stage
	logic                  busy_s1;
	logic [PIX_W-1:0]      pix_s1;
	logic [COORD_BITS-1:0] row0_s1, col0_s1;
	logic [CNT_W-1:0]      nrows_s1, ncols_s1;
	logic [CNT_W-1:0]      ri_s1, ci_s1;

	// Output register
	logic      out_valid_q;
	izps_out_t out_q;

	logic [ZOOM_W-1:0] zr, zc;
	logic [CNT_W-1:0]  nr, nc, nrv, ncv;
	logic [DIM_W-1:0]  rmax, cmax;
	logic              accept, step, last_rep, col_wrap;

	function automatic logic [ZOOM_W-1:0] eff_zoom(input logic [ZOOM_W-1:0] z);
		eff_zoom = (z > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : z;
	endfunction

	function automatic logic [BASE_W-1:0] sat_add(input logic [BASE_W-1:0] a,
			input logic [ZOOM_W-1:0] b);
		logic [BASE_W:0] s;
		s = {1'b0, a} + {{(BASE_W + 1 - ZOOM_W){1'b0}}, b};
		sat_add = s[BASE_W] ? {BASE_W{1'b1}} : s[BASE_W-1:0];
	endfunction

	// Number of writes left on one axis: min(count, room), zero when none.
	function automatic logic [CNT_W-1:0] clip_cnt(input logic [CNT_W-1:0] n,
			input logic [DIM_W-1:0] lim, input logic [BASE_W-1:0] base);
		logic [CMP_W-1:0] room;
		room = {{(CMP_W - DIM_W){1'b0}}, lim} - {1'b0, base};
		if ({{(CMP_W - DIM_W){1'b0}}, lim} <= {1'b0, base})
			clip_cnt = '0;
		else if (room >= {{(CMP_W - CNT_W){1'b0}}, n})
			clip_cnt = n;
		else
			clip_cnt = room[CNT_W-1:0];
	endfunction

	assign zr   = eff_zoom(zoom_rows_q);
	assign zc   = eff_zoom(zoom_cols_q);
	assign rmax = (dest_rows_q < DIM_W'(LIM)) ? dest_rows_q : DIM_W'(LIM);
	assign cmax = (dest_cols_q < DIM_W'(LIM)) ? dest_cols_q : DIM_W'(LIM);

	always_comb begin
		nr = '0;
		nc = '0;
		if (zr != '0 && zc != '0) begin
			nr = shrink_rows_q ? CNT_W'(1) : CNT_W'(zr);
			nc = shrink_cols_q ? CNT_W'(1) : CNT_W'(zc);
		end
	end

	assign nrv = clip_cnt(nr, rmax, row_base_q);
	assign ncv = clip_cnt(nc, cmax, col_base_q);

	assign step     = busy_s1 && (!out_valid_q || dst_ready);
	assign col_wrap = (CNT_W'(ci_s1 + CNT_W'(1)) == ncols_s1);
	assign last_rep = col_wrap && (CNT_W'(ri_s1 + CNT_W'(1)) == nrows_s1);

	assign src_ready = !busy_s1 || (step && last_rep);
	assign accept    = src_valid && src_ready;

	assign dst_valid = out_valid_q;
	assign dst       = out_q;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_rows_q   <= ZOOM_W'(1);
			shrink_rows_q <= 1'b0;
			zoom_cols_q   <= ZOOM_W'(1);
			shrink_cols_q <= 1'b0;
			dest_rows_q   <= DIM_W'(4096);
			dest_cols_q   <= DIM_W'(4096);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ZOOM_ROWS:   zoom_rows_q   <= cfg_data[ZOOM_W-1:0];
				REG_SHRINK_ROWS: shrink_rows_q <= cfg_data[0];
				REG_ZOOM_COLS:   zoom_cols_q   <= cfg_data[ZOOM_W-1:0];
				REG_SHRINK_COLS: shrink_cols_q <= cfg_data[0];
				REG_DEST_ROWS:   dest_rows_q   <= cfg_data[DIM_W-1:0];
				REG_DEST_COLS:   dest_cols_q   <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Position counters move on every source transfer, whether or not it writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_base_q  <= '0;
			row_phase_q <= '0;
			col_base_q  <= '0;
			col_phase_q <= '0;
		end else if (accept) begin
			if (src.frame_end) begin
				row_base_q  <= '0;
				row_phase_q <= '0;
				col_base_q  <= '0;
				col_phase_q <= '0;
			end else if (src.row_end) begin
				col_base_q  <= '0;
				col_phase_q <= '0;
				if (!shrink_rows_q) begin
					row_base_q  <= sat_add(row_base_q, zr);
					row_phase_q <= '0;
				end else if ({1'b0, ZOOM_W'(row_phase_q)} + (ZOOM_W + 1)'(1)
						>= {1'b0, zr}) begin
					row_base_q  <= sat_add(row_base_q, ZOOM_W'(1));
					row_phase_q <= '0;
				end else begin
					row_phase_q <= CNT_W'(row_phase_q + CNT_W'(1));
				end
			end else begin
				if (!shrink_cols_q) begin
					col_base_q  <= sat_add(col_base_q, zc);
					col_phase_q <= '0;
				end else if ({1'b0, ZOOM_W'(col_phase_q)} + (ZOOM_W + 1)'(1)
						>= {1'b0, zc}) begin
					col_base_q  <= sat_add(col_base_q, ZOOM_W'(1));
					col_phase_q <= '0;
				end else begin
					col_phase_q <= CNT_W'(col_phase_q + CNT_W'(1));
				end
			end
		end
	end

	// Replica stage: walks each row of the clipped write window column by column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			ri_s1   <= '0;
			ci_s1   <= '0;
		end else begin
			if (accept) begin
				busy_s1 <= (nrv != '0) && (ncv != '0);
				ri_s1   <= '0;
				ci_s1   <= '0;
			end else if (step) begin
				if (last_rep) begin
					busy_s1 <= 1'b0;
				end else if (col_wrap) begin
					ci_s1 <= '0;
					ri_s1 <= CNT_W'(ri_s1 + CNT_W'(1));
				end else begin
					ci_s1 <= CNT_W'(ci_s1 + CNT_W'(1));
				end
			end
		end
	end

	// Base values below the clip limit always fit the coordinate width.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= src.pixel_in;
			row0_s1  <= row_base_q[COORD_BITS-1:0];
			col0_s1  <= col_base_q[COORD_BITS-1:0];
			nrows_s1 <= nrv;
			ncols_s1 <= ncv;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (dst_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q.write_row  <= row0_s1 + COORD_BITS'(ri_s1);
			out_q.write_col  <= col0_s1 + COORD_BITS'(ci_s1);
			out_q.pixel_out  <= pix_s1;
			out_q.last_write <= last_rep;
		end
	end

endmodule

// ===== tb/sv/izps_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zoom scaler write checker
// Watches the source, destination and configuration ports of the scaler,
// predicts the addressed destination writes of every source transfer and
// compares each destination transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module izps_checker #(
	parameter int MAX_ZOOM = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               src_valid,
	input  logic                               src_ready,
	input  izps_pkg::izps_in_t                 src,
	input  logic                               dst_valid,
	input  logic                               dst_ready,
	input  izps_pkg::izps_out_t                dst,
	input  logic                               cfg_we,
	input  logic [izps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [izps_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                 fail_count,
	output int                                 outstanding
);

	import izps_pkg::*;

	localparam int COORD_LIMIT = 1 << COORD_BITS;
	localparam int PRINT_LIMIT = 40;

	logic [ZOOM_W-1:0] zoom_rows, zoom_cols;
	logic              shrink_rows, shrink_cols;
	logic [DIM_W-1:0]  dest_rows, dest_cols;
	logic [BASE_W-1:0] row_base, col_base;
	logic [2:0]        row_phase, col_phase;

	izps_out_t expected_writes[$];

	initial fail_count = 0;

	function automatic int clamp_zoom(logic [ZOOM_W-1:0] z);
		return (z > MAX_ZOOM) ? MAX_ZOOM : int'(z);
	endfunction

	function automatic logic [BASE_W-1:0] sat_add(logic [BASE_W-1:0] a, int b);
		int s;
		s = int'(a) + b;
		return (s > 16'hFFFF) ? 16'hFFFF : s[BASE_W-1:0];
	endfunction

	// Number of replicas starting at base that land below the clip limit.
	function automatic int span(int base, int count, int lim);
		if (base >= lim)
			return 0;
		return (count < lim - base) ? count : lim - base;
	endfunction

	// Steps one axis by one source element; returns {base, phase}.
	function automatic logic [BASE_W+2:0] step_axis(logic [BASE_W-1:0] base,
			logic [2:0] phase, int z, logic shrink);
		if (shrink) begin
			if (int'(phase) + 1 >= z)
				return {sat_add(base, 1), 3'd0};
			return {base, phase + 3'd1};
		end
		return {sat_add(base, z), 3'd0};
	endfunction

	task automatic report(input string msg);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic predict_writes(input izps_in_t px);
		int zr, zc, nr, nc, rows_hit, cols_hit, total, k, r, c;
		izps_out_t w;
		zr = clamp_zoom(zoom_rows);
		zc = clamp_zoom(zoom_cols);
		nr = 0;
		nc = 0;
		if (zr != 0 && zc != 0) begin
			nr = shrink_rows ? 1 : zr;
			nc = shrink_cols ? 1 : zc;
		end
		rows_hit = span(row_base, nr, (dest_rows < COORD_LIMIT) ? dest_rows : COORD_LIMIT);
		cols_hit = span(col_base, nc, (dest_cols < COORD_LIMIT) ? dest_cols : COORD_LIMIT);
		total = rows_hit * cols_hit;
		k = 0;
		for (int i = 0; i < rows_hit; i++) begin
			for (int j = 0; j < cols_hit; j++) begin
				r = int'(row_base) + i;
				c = int'(col_base) + j;
				k++;
				w.write_row  = r[COORD_BITS-1:0];
				w.write_col  = c[COORD_BITS-1:0];
				w.pixel_out  = px.pixel_in;
				w.last_write = (k == total);
				expected_writes.push_back(w);
			end
		end

		// Frame end restarts everything; row end restarts the columns.
		if (px.frame_end) begin
			row_base  = '0;
			row_phase = '0;
			col_base  = '0;
			col_phase = '0;
		end else if (px.row_end) begin
			col_base  = '0;
			col_phase = '0;
			{row_base, row_phase} = step_axis(row_base, row_phase, zr, shrink_rows);
		end else begin
			{col_base, col_phase} = step_axis(col_base, col_phase, zc, shrink_cols);
		end
	endtask

	task automatic check_write(input izps_out_t got);
		izps_out_t want;
		if (expected_writes.size() == 0) begin
			report($sformatf("unexpected write row %0d col %0d pixel %0d last %0d",
				got.write_row, got.write_col, got.pixel_out, got.last_write));
		end else begin
			want = expected_writes.pop_front();
			if (got.write_row !== want.write_row || got.write_col !== want.write_col ||
					got.pixel_out !== want.pixel_out || got.last_write !== want.last_write)
				report($sformatf("write got r%0d c%0d p%0d l%0d, expected r%0d c%0d p%0d l%0d",
					got.write_row, got.write_col, got.pixel_out, got.last_write,
					want.write_row, want.write_col, want.pixel_out, want.last_write));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_rows   = 4'd1;
			shrink_rows = 1'b0;
			zoom_cols   = 4'd1;
			shrink_cols = 1'b0;
			dest_rows   = 13'd4096;
			dest_cols   = 13'd4096;
			row_base    = '0;
			row_phase   = '0;
			col_base    = '0;
			col_phase   = '0;
			expected_writes.delete();
			outstanding <= 0;
		end else begin
			if (dst_valid && dst_ready)
				check_write(dst);
			if (src_valid && src_ready)
				predict_writes(src);
			if (cfg_we) begin
				case (cfg_index)
					REG_ZOOM_ROWS:   zoom_rows   = cfg_data[ZOOM_W-1:0];
					REG_SHRINK_ROWS: shrink_rows = cfg_data[0];
					REG_ZOOM_COLS:   zoom_cols   = cfg_data[ZOOM_W-1:0];
					REG_SHRINK_COLS: shrink_cols = cfg_data[0];
					REG_DEST_ROWS:   dest_rows   = cfg_data[DIM_W-1:0];
					REG_DEST_COLS:   dest_cols   = cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
			outstanding <= expected_writes.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer zoom pixel scaler testbench
// Drives raster pixels and register settings into the scaler with random
// gaps and back-pressure; the write checker beside it predicts and compares
// every destination write.
// ----------------------------------------------------------------------------
module tb;

	import izps_pkg::*;

	localparam int CYCLE_LIMIT   = 5_000_000;
	localparam int SETTLE_CYCLES = 80;
	localparam int RANDOM_PHASES = 11;
	localparam int PHASE_ITEMS   = 36;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  src_valid = 1'b0;
	logic                  src_ready;
	izps_in_t              src       = '0;
	logic                  dst_valid;
	logic                  dst_ready = 1'b0;
	izps_out_t             dst;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	bit src_calm    = 1'b0;
	bit dst_calm    = 1'b0;

	integer_zoom_pixel_scaler #(
		.MAX_ZOOM(8)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src(src),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.dst(dst),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	izps_checker #(
		.MAX_ZOOM(8)
	) write_check (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src(src),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.dst(dst),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int draw_wait(bit calm);
		if (calm)
			return 0;
		case ($urandom_range(0, 3))
			0, 1:    return 0;
			2:       return $urandom_range(1, 3);
			default: return $urandom_range(0, 18);
		endcase
	endfunction

	function automatic int pick_zoom();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return $urandom_range(9, 15);
			2:       return $urandom_range(5, 8);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return 4096;
			2:       return $urandom_range(4097, 8191);
			default: return $urandom_range(1, 48);
		endcase
	endfunction

	// Destination side: a fresh stall is drawn before every write transfer.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(dst_calm);
			if (stall > 0) begin
				dst_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			dst_ready <= 1'b1;
			do @(posedge clk); while (!dst_valid);
			@(negedge clk);
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic re, input logic fe);
		int gap;
		izps_in_t px;
		gap = draw_wait(src_calm);
		px.pixel_in  = pix;
		px.row_end   = re;
		px.frame_end = fe;
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src       <= px;
		src_valid <= 1'b1;
		do @(posedge clk); while (!src_ready);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		src_valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	// Once every expected write has arrived the block is idle; the extra
	// quiet cycles keep register writes well apart from the last transfer.
	task automatic settle();
		src_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		cfg_we    <= 1'b1;
		@(negedge clk);
	endtask

	task automatic load_config(input int zr, input int sr, input int zc, input int sc,
			input int drows, input int dcols);
		settle();
		write_reg(REG_ZOOM_ROWS, zr);
		write_reg(REG_SHRINK_ROWS, sr);
		write_reg(REG_ZOOM_COLS, zc);
		write_reg(REG_SHRINK_COLS, sc);
		write_reg(REG_DEST_ROWS, drows);
		write_reg(REG_DEST_COLS, dcols);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_run(input int count, input logic re);
		for (int i = 0; i < count; i++)
			send_pixel($urandom_range(0, 255), re, 1'b0);
	endtask

	// Well-formed raster frame; the final pixel may or may not carry row end too.
	task automatic send_frame(input int w, input int h);
		logic fin;
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				fin = (r == h - 1) && (c == w - 1);
				send_pixel($urandom_range(0, 255),
					(c == w - 1) ? (fin ? logic'($urandom_range(0, 1)) : 1'b1) : 1'b0, fin);
			end
		end
	endtask

	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++)
			send_pixel($urandom_range(0, 255), $urandom_range(0, 3) == 0,
				$urandom_range(0, 7) == 0);
	endtask

	initial begin
		int items, w, h, n;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: one write per pixel, row end and frame end marks.
		send_pixel(8'h00, 1'b0, 1'b0);
		send_pixel(8'hFF, 1'b0, 1'b0);
		send_pixel(8'hA5, 1'b1, 1'b0);
		send_pixel(8'h5A, 1'b0, 1'b0);
		send_pixel(8'h3C, 1'b1, 1'b1);

		// Largest expansion on both axes.
		load_config(8, 0, 8, 0, 4096, 4096);
		send_pixel(8'hFF, 1'b0, 1'b0);
		send_pixel(8'h00, 1'b1, 1'b0);
		send_pixel(8'h81, 1'b0, 1'b1);

		// Zooms above the maximum, column clipping, widest row limit.
		load_config(15, 1, 9, 0, 8191, 5);
		send_pixel(8'h11, 1'b0, 1'b0);
		send_pixel(8'h22, 1'b0, 1'b0);
		send_pixel(8'h33, 1'b1, 1'b0);
		send_pixel(8'h44, 1'b0, 1'b0);

		// Zero zoom writes nothing but the counters keep moving.
		load_config(0, 1, 2, 1, 4096, 4096);
		send_pixel(8'h55, 1'b0, 1'b0);
		send_pixel(8'h66, 1'b1, 1'b0);
		send_pixel(8'h77, 1'b0, 1'b0);

		// Shrink groups on both axes, last write wins.
		load_config(3, 1, 3, 1, 4096, 4096);
		send_run(5, 1'b0);
		send_pixel(8'h88, 1'b1, 1'b0);
		send_run(2, 1'b1);

		// Zero destination rows.
		load_config(2, 0, 4, 1, 0, 4096);
		send_run(2, 1'b0);
		send_pixel(8'h99, 1'b0, 1'b1);

		// Column clip edge reached in the middle of a replica burst.
		src_calm = 1'b1;
		load_config(1, 0, 8, 0, 4096, 20);
		send_run(4, 1'b0);
		send_pixel(8'h02, 1'b1, 1'b0);
		send_pixel(8'h03, 1'b0, 1'b1);

		// Same for the rows.
		load_config(8, 0, 1, 0, 20, 4096);
		send_run(4, 1'b1);
		send_pixel(8'h05, 1'b0, 1'b1);
		src_calm = 1'b0;

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_config(pick_zoom(), $urandom_range(0, 1), pick_zoom(), $urandom_range(0, 1),
				pick_dim(), pick_dim());
			src_calm = ($urandom_range(0, 3) == 0);
			dst_calm = ($urandom_range(0, 3) == 0);
			items = 0;
			while (items < PHASE_ITEMS) begin
				if ($urandom_range(0, 5) == 0)
					hold_until_drained();
				if ($urandom_range(0, 4) != 0) begin
					w = $urandom_range(1, 10);
					h = $urandom_range(1, 6);
					send_frame(w, h);
					items += w * h;
				end else begin
					n = $urandom_range(1, 6);
					send_noise(n);
					items += n;
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/izps_pkg.sv
rtl/integer_zoom_pixel_scaler.sv
tb/sv/izps_checker.sv
tb/sv/tb.sv
